// File: design/ipv4_dotted_quad_parser_top_defines.svh
// Assertion macros shared by the dotted-quad parser RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef IPV4_DOTTED_QUAD_PARSER_TOP_DEFINES_SVH
`define IPV4_DOTTED_QUAD_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IPV4DQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ipv4dq check failed");

// Next-cycle implication, disabled during reset.
`define IPV4DQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ipv4dq check failed");

`endif

// File: design/ipv4dq_pkg.sv
// Package for the dotted-quad parser: parse state and result types,
// character constants and the octet-close helper. No dependencies.
`default_nettype none

package ipv4dq_pkg;

  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [9:0] OCTET_MAX  = 10'd255;
  localparam logic [2:0] DIGITS_MAX = 3'd3;
  localparam logic [2:0] OCTETS_ALL = 3'd4;

  typedef struct packed {
    logic [2:0]  octet_count;
    logic [9:0]  octet_value;
    logic [2:0]  digit_count;
    logic [31:0] address_so_far;
    logic        failed_flag;
    logic        finished_flag;
  } parse_state_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] address;
  } parse_result_t;

  localparam parse_state_t STATE_RESET = '0;

  // Close the open octet: fail on an empty or oversized octet, else shift it in.
  function automatic parse_state_t close_octet(parse_state_t s);
    parse_state_t t;
    t = s;
    if (s.digit_count == 3'd0 || s.octet_value > OCTET_MAX) begin
      t.failed_flag = 1'b1;
    end else begin
      t.address_so_far = {s.address_so_far[23:0], s.octet_value[7:0]};
      t.octet_count    = s.octet_count + 3'd1;
      t.octet_value    = '0;
      t.digit_count    = '0;
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// File: design/ipv4dq_step.sv
// One character step of the dotted-quad parser, purely combinational.
// Depends on ipv4dq_pkg for the state and result types.
`default_nettype none

module ipv4dq_step (
  input  ipv4dq_pkg::parse_state_t  state,
  input  logic [7:0]                character,
  input  logic                      has_character,
  input  logic                      last,
  output ipv4dq_pkg::parse_state_t  state_next,
  output ipv4dq_pkg::parse_result_t result
);
  import ipv4dq_pkg::*;

  parse_state_t after_char;
  parse_state_t after_end;
  logic         is_digit;
  logic [3:0]   digit;
  logic [9:0]   times_ten;

  assign is_digit  = (character >= CH_ZERO) && (character <= CH_NINE);
  assign digit     = character[3:0];
  // v*10 as (v<<3)+(v<<1), kept to 10 bits
  assign times_ten = {state.octet_value[6:0], 3'b000} + {state.octet_value[8:0], 1'b0};

  // character update
  always_comb begin
    after_char = state;
    if (has_character && !state.failed_flag && !state.finished_flag) begin
      if (character == CH_DOT) begin
        after_char = close_octet(state);
        if (!after_char.failed_flag && after_char.octet_count >= OCTETS_ALL) begin
          after_char.finished_flag = 1'b1;
        end
      end else if (is_digit) begin
        if (state.digit_count >= DIGITS_MAX) begin
          after_char.failed_flag = 1'b1;
        end else begin
          after_char.octet_value = times_ten + {6'd0, digit};
          after_char.digit_count = state.digit_count + 3'd1;
        end
      end else begin
        after_char.failed_flag = 1'b1;
      end
    end
  end

  // end of string closes the open octet like a dot
  always_comb begin
    after_end = after_char;
    if (!after_char.failed_flag && !after_char.finished_flag) begin
      after_end = close_octet(after_char);
    end
  end

  // result and next state
  always_comb begin
    result.ok      = !after_end.failed_flag && (after_end.octet_count == OCTETS_ALL);
    result.address = result.ok ? after_end.address_so_far : 32'd0;
    state_next     = last ? STATE_RESET : after_char;
  end

endmodule

`default_nettype wire

// File: design/ipv4_dotted_quad_parser_top.sv
// Top level of the streaming dotted-quad parser: input register, step
// logic (ipv4dq_step), parse state and result register. Uses ipv4dq_pkg.
//
//  channel   dir  tdata            tuser           tlast
//  s_axis    in   character[7:0]   has_character   last
//  m_axis    out  address[31:0]    ok              -
//
// One item per cycle, save for a last item that waits for a stalled result; a
// result goes valid after its last item passes the input and result registers.
// rst is synchronous, active high, and clears both valid flags and the state.
// A stalled result holds the input register only for an item marked last;
// other items keep flowing while the result waits.
`default_nettype none
`include "ipv4_dotted_quad_parser_top_defines.svh"

module ipv4_dotted_quad_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] character
  input  logic        s_axis_tuser,   // [0] has_character
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] address
  output logic        m_axis_tuser    // [0] ok
);
  import ipv4dq_pkg::*;

  logic          in_valid;
  logic [7:0]    in_char;
  logic          in_has;
  logic          in_last;
  parse_state_t  state;
  parse_state_t  state_next;
  parse_result_t step_result;
  logic          out_valid;
  parse_result_t out_result;
  logic          out_free;
  logic          consume;

  assign out_free      = !out_valid || m_axis_tready;
  assign consume       = in_valid && (!in_last || out_free);
  assign s_axis_tready = !in_valid || consume;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_char <= s_axis_tdata;
      in_has  <= s_axis_tuser;
      in_last <= s_axis_tlast;
    end
  end

  ipv4dq_step u_step (
    .state         (state),
    .character     (in_char),
    .has_character (in_has),
    .last          (in_last),
    .state_next    (state_next),
    .result        (step_result)
  );

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (consume) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= consume && in_last;
    end
    if (consume && in_last) begin
      out_result <= step_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_result.address;
  assign m_axis_tuser  = out_result.ok;

  `IPV4DQ_ASSERT_NOW(a_no_overwrite, clk, rst, out_valid && !m_axis_tready, !(consume && in_last))
  `IPV4DQ_ASSERT_NOW(a_fail_zero, clk, rst, out_valid && !out_result.ok, out_result.address == 32'd0)
  `IPV4DQ_ASSERT_NEXT(a_end_clears, clk, rst, consume && in_last, state == STATE_RESET)
  `IPV4DQ_ASSERT_NOW(a_finished_four, clk, rst, state.finished_flag, state.octet_count == OCTETS_ALL)

endmodule

`default_nettype wire
